// ===== hdl/asq_pkg.sv =====
`timescale 1ns / 1ps

package asq_pkg;

  // Operating modes as held in the mode register (codes 6 and 7 are invalid)
  localparam logic [2:0] MODE_OPEN        = 3'd0;
  localparam logic [2:0] MODE_CLOSE       = 3'd1;
  localparam logic [2:0] MODE_FORCE_CLOSE = 3'd2;
  localparam logic [2:0] MODE_RAISE       = 3'd3;
  localparam logic [2:0] MODE_LOWER       = 3'd4;
  localparam logic [2:0] MODE_LOWER_TIMED = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_OPEN_TH  = 3'd1;
  localparam logic [2:0] REG_CLOSE_TH = 3'd2;
  localparam logic [2:0] REG_LIFT_TH  = 3'd3;
  localparam logic [2:0] REG_BAND     = 3'd4;
  localparam logic [2:0] REG_CONFIRM  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;

  // Reset values of the configuration registers
  localparam logic [2:0]  RST_MODE     = MODE_OPEN;
  localparam logic [11:0] RST_OPEN_TH  = 12'd1200;
  localparam logic [11:0] RST_CLOSE_TH = 12'd980;
  localparam logic [11:0] RST_LIFT_TH  = 12'd1500;
  localparam logic [11:0] RST_BAND     = 12'd50;
  localparam logic [5:0]  RST_CONFIRM  = 6'd10;
  localparam logic [15:0] RST_TIMEOUT  = 16'd1000;

  // Stop causes
  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_LEVEL   = 2'd1;
  localparam logic [1:0] CAUSE_STALL   = 2'd2;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd3;

  // Servo pulse values
  localparam logic [9:0] DUTY_OPEN    = 10'd125;
  localparam logic [9:0] DUTY_NEUTRAL = 10'd75;
  localparam logic [9:0] DUTY_CLOSE   = 10'd25;

  // Converter channels
  localparam logic [1:0] CHAN_UPPER   = 2'd0;
  localparam logic [1:0] CHAN_LOWER   = 2'd1;
  localparam logic [1:0] CHAN_GRIPPER = 2'd2;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] open_th;
    logic [11:0] close_th;
    logic [11:0] lift_th;
    logic [11:0] band;
    logic [5:0]  confirm;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [9:0] servo_duty;
    logic       motor_up;
    logic       motor_down;
    logic [1:0] adc_channel;
    logic       done;
    logic [1:0] cause;
  } res_t;

endpackage

// ===== hdl/asq_cfg_regs.sv =====
`timescale 1ns / 1ps

module asq_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output asq_pkg::cfg_t      cfg_o
);

  asq_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= asq_pkg::RST_MODE;
      cfg_q.open_th  <= asq_pkg::RST_OPEN_TH;
      cfg_q.close_th <= asq_pkg::RST_CLOSE_TH;
      cfg_q.lift_th  <= asq_pkg::RST_LIFT_TH;
      cfg_q.band     <= asq_pkg::RST_BAND;
      cfg_q.confirm  <= asq_pkg::RST_CONFIRM;
      cfg_q.timeout  <= asq_pkg::RST_TIMEOUT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        asq_pkg::REG_MODE:     cfg_q.mode     <= cfg_data_i[2:0];
        asq_pkg::REG_OPEN_TH:  cfg_q.open_th  <= cfg_data_i[11:0];
        asq_pkg::REG_CLOSE_TH: cfg_q.close_th <= cfg_data_i[11:0];
        asq_pkg::REG_LIFT_TH:  cfg_q.lift_th  <= cfg_data_i[11:0];
        asq_pkg::REG_BAND:     cfg_q.band     <= cfg_data_i[11:0];
        asq_pkg::REG_CONFIRM:  cfg_q.confirm  <= cfg_data_i[5:0];
        asq_pkg::REG_TIMEOUT:  cfg_q.timeout  <= cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/asq_step.sv =====
`timescale 1ns / 1ps

module asq_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic           start_i,
  input  logic [7:0]     reply_high_i,
  input  logic [7:0]     reply_low_i,
  input  asq_pkg::cfg_t  cfg_i,
  output asq_pkg::res_t  res_o
);

  logic        moving_q, moving_d;
  logic [6:0]  level_q, level_d;
  logic [6:0]  steady_q, steady_d;
  logic [11:0] last_q, last_d;
  logic [16:0] elapsed_q, elapsed_d;

  logic [11:0] sample;
  logic [11:0] thresh;
  logic        mode_ok;
  logic [6:0]  level_inc;
  logic [6:0]  steady_inc;
  logic        in_band;
  logic [1:0]  cause;

  assign sample     = {reply_high_i[3:0], reply_low_i};
  assign mode_ok    = (cfg_i.mode <= asq_pkg::MODE_LOWER_TIMED);
  assign level_inc  = level_q + 7'd1;
  assign steady_inc = steady_q + 7'd1;
  assign in_band    = (({1'b0, sample} + {1'b0, cfg_i.band}) > {1'b0, last_q}) &&
                      ({1'b0, sample} < ({1'b0, last_q} + {1'b0, cfg_i.band}));

  always_comb begin
    if (cfg_i.mode == asq_pkg::MODE_OPEN) begin
      thresh = cfg_i.open_th;
    end else if (cfg_i.mode <= asq_pkg::MODE_FORCE_CLOSE) begin
      thresh = cfg_i.close_th;
    end else begin
      thresh = cfg_i.lift_th;
    end
  end

  always_comb begin
    moving_d  = moving_q;
    level_d   = level_q;
    steady_d  = steady_q;
    last_d    = last_q;
    elapsed_d = elapsed_q;
    cause     = asq_pkg::CAUSE_NONE;
    if (start_i) begin
      moving_d  = mode_ok;
      level_d   = '0;
      steady_d  = '0;
      last_d    = '0;
      elapsed_d = '0;
    end else if (moving_q && !mode_ok) begin
      moving_d = 1'b0;
    end else if (moving_q) begin
      if (cfg_i.mode == asq_pkg::MODE_LOWER_TIMED && elapsed_q > {1'b0, cfg_i.timeout}) begin
        cause = asq_pkg::CAUSE_TIMEOUT;
      end else begin
        // leaky level counter: up above threshold, down by one toward zero otherwise
        if (sample > thresh) begin
          level_d = level_inc;
          if (level_inc > {1'b0, cfg_i.confirm}) begin
            cause = asq_pkg::CAUSE_LEVEL;
          end
        end else if (level_q != '0) begin
          level_d = level_q - 7'd1;
        end
        if (cause == asq_pkg::CAUSE_NONE && cfg_i.mode == asq_pkg::MODE_CLOSE) begin
          if (in_band) begin
            steady_d = steady_inc;
            if (steady_inc > {1'b0, cfg_i.confirm}) begin
              cause = asq_pkg::CAUSE_STALL;
            end
          end else begin
            steady_d = '0;
          end
        end
        last_d = sample;
        if (elapsed_q != asq_pkg::ELAPSED_MAX) begin
          elapsed_d = elapsed_q + 17'd1;
        end
      end
      if (cause != asq_pkg::CAUSE_NONE) begin
        moving_d = 1'b0;
      end
    end
  end

  // Drive after this item, neutral unless still moving
  always_comb begin
    res_o.servo_duty  = asq_pkg::DUTY_NEUTRAL;
    res_o.motor_up    = 1'b0;
    res_o.motor_down  = 1'b0;
    res_o.adc_channel = asq_pkg::CHAN_UPPER;
    res_o.done        = (cause != asq_pkg::CAUSE_NONE);
    res_o.cause       = cause;
    unique case (cfg_i.mode) inside
      asq_pkg::MODE_OPEN: begin
        res_o.adc_channel = asq_pkg::CHAN_GRIPPER;
        if (moving_d) res_o.servo_duty = asq_pkg::DUTY_OPEN;
      end
      asq_pkg::MODE_CLOSE, asq_pkg::MODE_FORCE_CLOSE: begin
        res_o.adc_channel = asq_pkg::CHAN_GRIPPER;
        if (moving_d) res_o.servo_duty = asq_pkg::DUTY_CLOSE;
      end
      asq_pkg::MODE_RAISE: begin
        res_o.adc_channel = asq_pkg::CHAN_UPPER;
        res_o.motor_up    = moving_d;
      end
      asq_pkg::MODE_LOWER, asq_pkg::MODE_LOWER_TIMED: begin
        res_o.adc_channel = asq_pkg::CHAN_LOWER;
        res_o.motor_down  = moving_d;
      end
      default: ; // invalid mode: neutral drive on the upper channel
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q  <= 1'b0;
      level_q   <= '0;
      steady_q  <= '0;
      last_q    <= '0;
      elapsed_q <= '0;
    end else if (fire_i) begin
      moving_q  <= moving_d;
      level_q   <= level_d;
      steady_q  <= steady_d;
      last_q    <= last_d;
      elapsed_q <= elapsed_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_ends_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.done) |=> !moving_q)
    else $error("motion still active after a stopping item");

  a_idle_sample_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !start_i && !moving_q) |->
      (res_o.cause == asq_pkg::CAUSE_NONE && res_o.servo_duty == asq_pkg::DUTY_NEUTRAL &&
       !res_o.motor_up && !res_o.motor_down))
    else $error("sample while idle produced drive or stop");

  a_elapsed_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !start_i) |=> (elapsed_q >= $past(elapsed_q)))
    else $error("elapsed count went backwards without a start");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && start_i) |=>
      (level_q == '0 && steady_q == '0 && last_q == '0 && elapsed_q == '0))
    else $error("start did not clear the counters");

  a_stall_only_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.cause == asq_pkg::CAUSE_STALL) |-> (cfg_i.mode == asq_pkg::MODE_CLOSE))
    else $error("stall stop outside close mode");
`endif

endmodule

// ===== hdl/actuator_stop_qualifier_core.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   start_req_i, reply_high_i, reply_low_i
// out      output     out_valid_o / out_ready_i servo_duty_o, motor_up_o, motor_down_o,
//                                               adc_channel_o, done_res_o, stop_cause_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled. An accepted item is held in
// the input register, and the decision logic and counter update run between it and the
// result register, from which the result is offered.
// Reset clears the motion state and loads the register defaults; no clearing pass.
// A stalled output holds the result register and, through it, the input register.

module actuator_stop_qualifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic [7:0]  reply_high_i,
  input  logic [7:0]  reply_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  servo_duty_o,
  output logic        motor_up_o,
  output logic        motor_down_o,
  output logic [1:0]  adc_channel_o,
  output logic        done_res_o,
  output logic [1:0]  stop_cause_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  asq_pkg::cfg_t cfg;
  asq_pkg::res_t res;
  asq_pkg::res_t res_q;

  logic       s1_valid_q;
  logic       s1_start_q;
  logic [7:0] s1_high_q;
  logic [7:0] s1_low_q;
  logic       out_valid_q;
  logic       out_free;
  logic       fire;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;

  asq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  asq_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .start_i      (s1_start_q),
    .reply_high_i (s1_high_q),
    .reply_low_i  (s1_low_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= s1_valid_q;
    end
  end

  // Payload registers: input on acceptance, result on fire; hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_start_q <= start_req_i;
      s1_high_q  <= reply_high_i;
      s1_low_q   <= reply_low_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign servo_duty_o  = res_q.servo_duty;
  assign motor_up_o    = res_q.motor_up;
  assign motor_down_o  = res_q.motor_down;
  assign adc_channel_o = res_q.adc_channel;
  assign done_res_o    = res_q.done;
  assign stop_cause_o  = res_q.cause;

endmodule

// ===== bench/actuator_stop_qualifier_core_test.sv =====
`timescale 1ns / 1ps

module actuator_stop_qualifier_core_test;

  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam logic [2:0] REG_SPARE  = 3'd7;
  localparam int RANDOM_ITEMS = 840;

  typedef struct packed {
    logic       start;
    logic [7:0] hi;
    logic [7:0] lo;
  } item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        start_req_i = 1'b0;
  logic [7:0]  reply_high_i = '0;
  logic [7:0]  reply_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  servo_duty_o;
  logic        motor_up_o;
  logic        motor_down_o;
  logic [1:0]  adc_channel_o;
  logic        done_res_o;
  logic [1:0]  stop_cause_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  item_t          planned_items[$];
  asq_pkg::res_t  expected_drive_q[$];

  // shadow of the block's registers and motion state
  asq_pkg::cfg_t shadow_cfg;
  logic        in_motion;
  logic [6:0]  level_cnt;
  logic [6:0]  steady_cnt;
  logic [11:0] last_smp;
  logic [16:0] elapsed_cnt;

  bit idle_on = 1'b1;
  bit item_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_cycles = 0;
  int gen_prev = 0;
  int err_cnt = 0;
  int results_seen = 0;
  int items_fed = 0;
  int motion_items = 0;
  int phases = 0;
  int stops [4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  actuator_stop_qualifier_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_req_i   (start_req_i),
    .reply_high_i  (reply_high_i),
    .reply_low_i   (reply_low_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .servo_duty_o  (servo_duty_o),
    .motor_up_o    (motor_up_o),
    .motor_down_o  (motor_down_o),
    .adc_channel_o (adc_channel_o),
    .done_res_o    (done_res_o),
    .stop_cause_o  (stop_cause_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  task automatic note_error(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Advance the motion state by one item and return the drive it leaves.
  function automatic asq_pkg::res_t qualify_item(input logic st, input logic [7:0] hi,
                                                 input logic [7:0] lo);
    logic [2:0]    m;
    logic          ok;
    logic          fin;
    logic [1:0]    cause;
    logic [11:0]   smp;
    logic [11:0]   th;
    int            s_i;
    int            prev_i;
    int            band_i;
    asq_pkg::res_t r;
    m = shadow_cfg.mode;
    ok = (m <= asq_pkg::MODE_LOWER_TIMED);
    fin = 1'b0;
    cause = asq_pkg::CAUSE_NONE;
    if (st) begin
      level_cnt = '0;
      steady_cnt = '0;
      last_smp = '0;
      elapsed_cnt = '0;
      in_motion = ok;
    end else if (in_motion && !ok) begin
      in_motion = 1'b0;
    end else if (in_motion) begin
      smp = {hi[3:0], lo};
      if (m == asq_pkg::MODE_OPEN) th = shadow_cfg.open_th;
      else if (m <= asq_pkg::MODE_FORCE_CLOSE) th = shadow_cfg.close_th;
      else th = shadow_cfg.lift_th;
      if (m == asq_pkg::MODE_LOWER_TIMED && elapsed_cnt > {1'b0, shadow_cfg.timeout}) begin
        cause = asq_pkg::CAUSE_TIMEOUT;
      end else begin
        if (smp > th) begin
          level_cnt = level_cnt + 7'd1;
          if (level_cnt > {1'b0, shadow_cfg.confirm}) cause = asq_pkg::CAUSE_LEVEL;
        end else if (level_cnt != 7'd0) begin
          level_cnt = level_cnt - 7'd1;
        end
        if (cause == asq_pkg::CAUSE_NONE && m == asq_pkg::MODE_CLOSE) begin
          s_i = int'(smp);
          prev_i = int'(last_smp);
          band_i = int'(shadow_cfg.band);
          if (s_i + band_i > prev_i && s_i < prev_i + band_i) begin
            steady_cnt = steady_cnt + 7'd1;
            if (steady_cnt > {1'b0, shadow_cfg.confirm}) cause = asq_pkg::CAUSE_STALL;
          end else begin
            steady_cnt = '0;
          end
        end
        last_smp = smp;
        if (elapsed_cnt < asq_pkg::ELAPSED_MAX) elapsed_cnt = elapsed_cnt + 17'd1;
      end
      if (cause != asq_pkg::CAUSE_NONE) begin
        fin = 1'b1;
        in_motion = 1'b0;
      end
    end
    r.servo_duty = asq_pkg::DUTY_NEUTRAL;
    r.motor_up = 1'b0;
    r.motor_down = 1'b0;
    if (in_motion) begin
      case (m)
        asq_pkg::MODE_OPEN:
          r.servo_duty = asq_pkg::DUTY_OPEN;
        asq_pkg::MODE_CLOSE, asq_pkg::MODE_FORCE_CLOSE:
          r.servo_duty = asq_pkg::DUTY_CLOSE;
        asq_pkg::MODE_RAISE:
          r.motor_up = 1'b1;
        asq_pkg::MODE_LOWER, asq_pkg::MODE_LOWER_TIMED:
          r.motor_down = 1'b1;
        default: ;
      endcase
    end
    if (m <= asq_pkg::MODE_FORCE_CLOSE) r.adc_channel = asq_pkg::CHAN_GRIPPER;
    else if (m == asq_pkg::MODE_RAISE) r.adc_channel = asq_pkg::CHAN_UPPER;
    else if (m <= asq_pkg::MODE_LOWER_TIMED) r.adc_channel = asq_pkg::CHAN_LOWER;
    else r.adc_channel = asq_pkg::CHAN_UPPER;
    r.done = fin;
    r.cause = cause;
    return r;
  endfunction

  always @(negedge clk_i) begin : feed
    item_t nxt;
    logic  nv;
    nxt = {start_req_i, reply_high_i, reply_low_i};
    nv = in_valid_i;
    if (!in_valid_i || item_taken) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (planned_items.size() != 0) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 6);
        end else begin
          nxt = planned_items.pop_front();
          nv = 1'b1;
        end
      end
    end
    item_taken = 1'b0;
    in_valid_i <= nv;
    start_req_i <= nxt.start;
    reply_high_i <= nxt.hi;
    reply_low_i <= nxt.lo;
  end

  always @(negedge clk_i) begin : drain_side
    logic rdy;
    rdy = 1'b1;
    if (hold_cycles > 0) begin
      rdy = 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      rdy = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rdy = 1'b0;
      stall_left = $urandom_range(0, 6);
    end
    out_ready_i <= rdy;
  end

  always @(posedge clk_i) begin : watch
    asq_pkg::res_t got;
    asq_pkg::res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (start_req_i || in_motion) motion_items++;
        expected_drive_q.push_back(qualify_item(start_req_i, reply_high_i, reply_low_i));
        item_taken = 1'b1;
        items_fed++;
      end
      if (out_valid_o && out_ready_i) begin
        got = {servo_duty_o, motor_up_o, motor_down_o, adc_channel_o, done_res_o,
               stop_cause_o};
        results_seen++;
        if (expected_drive_q.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = expected_drive_q.pop_front();
          stops[want.cause]++;
          if (got.servo_duty !== want.servo_duty)
            note_error($sformatf("result %0d servo_duty %0d, want %0d", results_seen,
                                 got.servo_duty, want.servo_duty));
          if (got.motor_up !== want.motor_up)
            note_error($sformatf("result %0d motor_up %0b, want %0b", results_seen,
                                 got.motor_up, want.motor_up));
          if (got.motor_down !== want.motor_down)
            note_error($sformatf("result %0d motor_down %0b, want %0b", results_seen,
                                 got.motor_down, want.motor_down));
          if (got.adc_channel !== want.adc_channel)
            note_error($sformatf("result %0d adc_channel %0d, want %0d", results_seen,
                                 got.adc_channel, want.adc_channel));
          if (got.done !== want.done)
            note_error($sformatf("result %0d done_res %0b, want %0b", results_seen,
                                 got.done, want.done));
          if (got.cause !== want.cause)
            note_error($sformatf("result %0d stop_cause %0d, want %0d", results_seen,
                                 got.cause, want.cause));
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      asq_pkg::REG_MODE:     shadow_cfg.mode = val[2:0];
      asq_pkg::REG_OPEN_TH:  shadow_cfg.open_th = val[11:0];
      asq_pkg::REG_CLOSE_TH: shadow_cfg.close_th = val[11:0];
      asq_pkg::REG_LIFT_TH:  shadow_cfg.lift_th = val[11:0];
      asq_pkg::REG_BAND:     shadow_cfg.band = val[11:0];
      asq_pkg::REG_CONFIRM:  shadow_cfg.confirm = val[5:0];
      asq_pkg::REG_TIMEOUT:  shadow_cfg.timeout = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write every register; unused upper data bits carry junk now and then.
  task automatic load_cfg(input asq_pkg::cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom);
    if ($urandom_range(0, 3) != 0) junk = '0;
    write_reg(asq_pkg::REG_OPEN_TH, {junk[15:12], c.open_th});
    write_reg(asq_pkg::REG_CLOSE_TH, {junk[15:12], c.close_th});
    write_reg(asq_pkg::REG_LIFT_TH, {junk[15:12], c.lift_th});
    write_reg(asq_pkg::REG_BAND, {junk[15:12], c.band});
    write_reg(asq_pkg::REG_CONFIRM, {junk[15:6], c.confirm});
    write_reg(asq_pkg::REG_TIMEOUT, c.timeout);
    write_reg(asq_pkg::REG_MODE, {junk[15:3], c.mode});
    end_writes();
  endtask

  task automatic set_mode(input logic [2:0] m);
    write_reg(asq_pkg::REG_MODE, {13'd0, m});
    end_writes();
  endtask

  task automatic wait_quiet();
    while (planned_items.size() != 0 || in_valid_i || expected_drive_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_item(input logic st, input logic [7:0] hi, input logic [7:0] lo);
    planned_items.push_back({st, hi, lo});
    if (st) gen_prev = 0;
  endtask

  task automatic push_sample(input int v);
    logic [11:0] s;
    logic [3:0]  junk;
    if (v < 0) s = '0;
    else if (v > 4095) s = 12'hFFF;
    else s = v[11:0];
    junk = 4'($urandom);
    gen_prev = int'(s);
    push_item(1'b0, {junk, s[11:8]}, s[7:0]);
  endtask

  // Mix samples near the threshold, near the previous sample, noise, and raw random items.
  task automatic queue_samples(input asq_pkg::cfg_t c, input int len);
    int          k;
    int          th;
    int          b;
    logic [31:0] rnd;
    if (c.mode == asq_pkg::MODE_OPEN) th = int'(c.open_th);
    else if (c.mode <= asq_pkg::MODE_FORCE_CLOSE) th = int'(c.close_th);
    else th = int'(c.lift_th);
    b = int'(c.band);
    for (k = 0; k < len; k++) begin
      rnd = $urandom;
      case ($urandom_range(0, 9))
        0:          push_item(rnd[16], rnd[15:8], rnd[7:0]);
        1, 2, 3, 4: push_sample(th + int'($urandom_range(0, 50)) - 15);
        5, 6, 7:    push_sample(gen_prev + int'($urandom_range(0, 2 * b)) - b);
        default:    push_sample(int'(rnd[11:0]));
      endcase
    end
  endtask

  function automatic logic [2:0] pick_mode();
    logic [2:0] m;
    if ($urandom_range(0, 11) == 0) m = $urandom_range(0, 1) ? MODE_RSVD7 : MODE_RSVD6;
    else m = 3'($urandom_range(0, 5));
    return m;
  endfunction

  function automatic logic [11:0] pick_level();
    logic [11:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = 12'hFFF;
      default: v = 12'($urandom_range(300, 3800));
    endcase
    return v;
  endfunction

  function automatic asq_pkg::cfg_t random_cfg();
    asq_pkg::cfg_t c;
    int            r;
    c.mode = pick_mode();
    c.open_th = pick_level();
    c.close_th = pick_level();
    c.lift_th = pick_level();
    r = $urandom_range(0, 9);
    if (r == 0) c.band = '0;
    else if (r == 1) c.band = 12'hFFF;
    else c.band = 12'($urandom_range(1, 150));
    r = $urandom_range(0, 9);
    if (r == 0) c.confirm = '0;
    else if (r == 1) c.confirm = 6'd63;
    else c.confirm = 6'($urandom_range(1, 12));
    r = $urandom_range(0, 9);
    if (r == 0) c.timeout = '0;
    else if (r == 1) c.timeout = 16'hFFFF;
    else c.timeout = 16'($urandom_range(0, 60));
    return c;
  endfunction

  initial begin : main
    asq_pkg::cfg_t c;
    int            base;
    shadow_cfg = '{asq_pkg::RST_MODE, asq_pkg::RST_OPEN_TH, asq_pkg::RST_CLOSE_TH,
                   asq_pkg::RST_LIFT_TH, asq_pkg::RST_BAND, asq_pkg::RST_CONFIRM,
                   asq_pkg::RST_TIMEOUT};
    in_motion = 1'b0;
    level_cnt = '0;
    steady_cnt = '0;
    last_smp = '0;
    elapsed_cnt = '0;
    c = shadow_cfg;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // samples with no motion running are ignored
    push_item(1'b0, 8'hFF, 8'hFF);
    push_item(1'b0, 8'h00, 8'h00);
    wait_quiet();
    write_reg(REG_SPARE, 16'hFFFF);
    c.confirm = '0;
    load_cfg(c);
    push_item(1'b1, 8'hFF, 8'hFF);
    push_item(1'b0, 8'hFF, 8'hFF);
    wait_quiet();
    // level and stall both reach the limit on one sample: level wins
    c.mode = asq_pkg::MODE_CLOSE;
    c.close_th = '0;
    c.band = 12'hFFF;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'hF0, 8'h05);
    wait_quiet();
    c.close_th = 12'hFFF;
    c.confirm = 6'd1;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h00, 8'h00);
    push_item(1'b0, 8'h00, 8'h00);
    wait_quiet();
    c.mode = asq_pkg::MODE_FORCE_CLOSE;
    c.close_th = 12'hFFE;
    c.confirm = '0;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h0F, 8'hFF);
    wait_quiet();
    c.mode = asq_pkg::MODE_RAISE;
    c.lift_th = '0;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'hF0, 8'h00);
    push_item(1'b0, 8'h00, 8'h01);
    wait_quiet();
    c.mode = asq_pkg::MODE_LOWER;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h0F, 8'hFF);
    wait_quiet();
    c.mode = asq_pkg::MODE_LOWER_TIMED;
    c.lift_th = 12'hFFF;
    c.timeout = '0;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h05, 8'h55);
    push_item(1'b0, 8'h0A, 8'hAA);
    wait_quiet();
    // invalid mode: a start clears but does not move
    c.mode = MODE_RSVD6;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h0F, 8'hFF);
    wait_quiet();
    // invalid mode written while moving drops the motion
    c.mode = asq_pkg::MODE_OPEN;
    c.open_th = 12'hFFF;
    load_cfg(c);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h01, 8'h23);
    wait_quiet();
    set_mode(MODE_RSVD7);
    push_item(1'b0, 8'h01, 8'h23);
    wait_quiet();
    // mode changed mid-motion: the next item uses the new mode
    set_mode(asq_pkg::MODE_OPEN);
    push_item(1'b1, 8'h00, 8'h00);
    push_item(1'b0, 8'h00, 8'h10);
    wait_quiet();
    set_mode(asq_pkg::MODE_RAISE);
    push_item(1'b0, 8'h00, 8'h10);
    wait_quiet();

    base = items_fed;
    while (items_fed - base < RANDOM_ITEMS) begin
      c = random_cfg();
      idle_on = (items_fed - base < RANDOM_ITEMS * 5 / 6) && $urandom_range(0, 4) != 0;
      load_cfg(c);
      // hold the output long enough to back up the input
      if (phases == 1) hold_cycles = 80;
      repeat ($urandom_range(1, 4)) begin
        push_item(1'b1, 8'($urandom), 8'($urandom));
        queue_samples(c, $urandom_range(3, 40));
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_quiet();
        c.mode = pick_mode();
        set_mode(c.mode);
        queue_samples(c, $urandom_range(3, 15));
      end
      wait_quiet();
      phases++;
    end

    repeat (5) @(posedge clk_i);
    $display("Covered %0d items (%0d in or starting a motion), %0d results, %0d random phases.",
             items_fed, motion_items, results_seen, phases);
    $display("Stops by level %0d, by stall %0d, by timeout %0d.",
             stops[asq_pkg::CAUSE_LEVEL], stops[asq_pkg::CAUSE_STALL],
             stops[asq_pkg::CAUSE_TIMEOUT]);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding", expected_drive_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
